### hdl/nst_pkg.sv
package nst_pkg;

  localparam int COORD_BITS  = 16;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int TOL_W       = 12;
  localparam int SEG_W       = 4 * COORD_BITS;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_FIND   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [IDX_W-1:0]             slot;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             hit;
    logic [IDX_W-1:0] hit_index;
    logic [CNT_W-1:0] entry_count;
  } out_rsp_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
  } seg_t;

endpackage

### hdl/nst_ram.sv
module nst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/nearest_segment_table.sv
// Add, clear, bad or last-slot remove, full add and find on an empty table:
// result in the cycle after start. Remove: each moved entry is read from RAM,
// then written back one slot lower. Find: walks the held segments, running a
// bit-serial divide for a segment when the projection lands inside it.
// One request at a time; out_valid is a single-cycle strobe, no stall.
// Synchronous active-low reset empties the table and sets tolerance to 8.
module nearest_segment_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  nst_pkg::in_req_t  in_req,
  output logic              out_valid,
  output nst_pkg::out_rsp_t out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [11:0]       cfg_data
);
  import nst_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int AB_W  = C + 1;
  localparam int PR_W  = 2 * AB_W;
  localparam int DOT_W = PR_W + 1;
  localparam int REM_W = DOT_W + 1;
  localparam int T_W   = 17;
  localparam int MX_W  = AB_W + T_W;
  localparam int RX_W  = MX_W - 15;
  localparam int D_W   = RX_W + 3;
  localparam int SQ_W  = 2 * D_W;
  localparam int D2_W  = SQ_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RM_RD = 4'd1;
  localparam logic [3:0] S_RM_WR = 4'd2;
  localparam logic [3:0] S_F_RD  = 4'd3;
  localparam logic [3:0] S_F_SUB = 4'd4;
  localparam logic [3:0] S_F_M1  = 4'd5;
  localparam logic [3:0] S_F_M2  = 4'd6;
  localparam logic [3:0] S_F_LEN = 4'd7;
  localparam logic [3:0] S_F_DIV = 4'd8;
  localparam logic [3:0] S_F_SC  = 4'd9;
  localparam logic [3:0] S_F_RND = 4'd10;
  localparam logic [3:0] S_F_SQ  = 4'd11;
  localparam logic [3:0] S_F_CMP = 4'd12;

  logic [3:0]       state_r;
  logic [CNT_W-1:0] count_r;
  logic [TOL_W-1:0] tol_r;
  logic [2*TOL_W-1:0] tol2_r;
  logic [IDX_W-1:0] idx_r;
  logic signed [C-1:0] qx_r, qy_r, sx_r, sy_r;
  logic signed [AB_W-1:0] abx_r, aby_r, acx_r, acy_r;
  logic signed [PR_W-1:0] pdx_r, pdy_r, lxx_r, lyy_r;
  logic signed [DOT_W-1:0] dot_r;
  logic [DOT_W-1:0] len2_r;
  logic [REM_W-1:0] rem_r;
  logic [T_W-1:0]   t_r;
  logic [3:0]       bit_cnt_r;
  logic [MX_W-1:0]  mx_r, my_r;
  logic signed [D_W-1:0]  dx_r, dy_r;
  logic signed [SQ_W-1:0] sqx_r, sqy_r;
  logic             hit_r;
  logic [IDX_W-1:0] hidx_r;
  logic [D2_W-1:0]  best_r;
  logic             out_valid_r;
  out_rsp_t         out_rsp_r;

  logic             accept;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [SEG_W-1:0] ram_wdata, ram_rdata;
  seg_t             seg;
  seg_t             add_seg;

  logic [DOT_W-1:0] len2_w;
  logic             dot_pos;
  logic [REM_W-1:0] r2;
  logic             ge;
  logic [AB_W-1:0]  magx, magy;
  logic [MX_W:0]    rsx, rsy;
  logic signed [D_W-1:0] offx, offy, dx_w, dy_w;
  logic [D2_W-1:0]  d2;
  logic             better;
  logic [IDX_W-1:0] last_idx;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign seg = seg_t'(ram_rdata);
  assign add_seg.sx = in_req.point_x;
  assign add_seg.sy = in_req.point_y;
  assign add_seg.ex = in_req.end_x;
  assign add_seg.ey = in_req.end_y;

  assign last_idx = IDX_W'(count_r - CNT_W'(1));

  // write port: append on add, shift down during remove
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    if (state_r == S_IDLE && accept && in_req.mode == MODE_ADD &&
        count_r < CNT_W'(TABLE_DEPTH)) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[IDX_W-1:0];
      ram_wdata = SEG_W'(add_seg);
    end else if (state_r == S_RM_WR) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = (state_r == S_RM_RD) || (state_r == S_F_RD);
  assign ram_raddr = (state_r == S_RM_RD) ? IDX_W'(idx_r + IDX_W'(1)) : idx_r;

  nst_ram #(.WIDTH(SEG_W), .DEPTH(TABLE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // projection datapath
  assign len2_w  = DOT_W'($unsigned(lxx_r)) + DOT_W'($unsigned(lyy_r));
  assign dot_pos = !dot_r[DOT_W-1] && (dot_r != '0);
  assign r2      = {rem_r[REM_W-2:0], 1'b0};
  assign ge      = (r2 >= {1'b0, len2_r});
  assign magx    = abx_r[AB_W-1] ? AB_W'(-abx_r) : AB_W'(abx_r);
  assign magy    = aby_r[AB_W-1] ? AB_W'(-aby_r) : AB_W'(aby_r);
  assign rsx     = {1'b0, mx_r} + (MX_W+1)'(32768);
  assign rsy     = {1'b0, my_r} + (MX_W+1)'(32768);
  assign offx    = abx_r[AB_W-1] ? -$signed(D_W'(rsx[MX_W:16]))
                                 :  $signed(D_W'(rsx[MX_W:16]));
  assign offy    = aby_r[AB_W-1] ? -$signed(D_W'(rsy[MX_W:16]))
                                 :  $signed(D_W'(rsy[MX_W:16]));
  assign dx_w    = $signed({{(D_W-C){qx_r[C-1]}}, qx_r})
                 - $signed({{(D_W-C){sx_r[C-1]}}, sx_r}) - offx;
  assign dy_w    = $signed({{(D_W-C){qy_r[C-1]}}, qy_r})
                 - $signed({{(D_W-C){sy_r[C-1]}}, sy_r}) - offy;
  assign d2      = D2_W'($unsigned(sqx_r)) + D2_W'($unsigned(sqy_r));
  assign better  = (d2 <= D2_W'(tol2_r)) && (!hit_r || d2 < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tol_r       <= TOL_W'(8);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_rsp_r.status    <= ST_OK;
            out_rsp_r.hit       <= 1'b0;
            out_rsp_r.hit_index <= '0;
            out_rsp_r.entry_count <= count_r;
            qx_r   <= in_req.point_x;
            qy_r   <= in_req.point_y;
            idx_r  <= in_req.slot;
            tol2_r <= tol_r * tol_r;
            hit_r  <= 1'b0;
            best_r <= '0;
            hidx_r <= '0;
            case (in_req.mode)
              MODE_ADD: begin
                out_valid_r <= 1'b1;
                if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                  out_rsp_r.status <= ST_FULL;
                end else begin
                  count_r               <= count_r + CNT_W'(1);
                  out_rsp_r.entry_count <= count_r + CNT_W'(1);
                end
              end
              MODE_REMOVE: begin
                if (CNT_W'(in_req.slot) >= count_r) begin
                  out_valid_r      <= 1'b1;
                  out_rsp_r.status <= ST_BAD_INDEX;
                end else if (in_req.slot == last_idx) begin
                  out_valid_r           <= 1'b1;
                  count_r               <= count_r - CNT_W'(1);
                  out_rsp_r.entry_count <= count_r - CNT_W'(1);
                end else begin
                  state_r <= S_RM_RD;
                end
              end
              MODE_CLEAR: begin
                out_valid_r           <= 1'b1;
                count_r               <= '0;
                out_rsp_r.entry_count <= '0;
              end
              default: begin
                idx_r <= '0;
                if (count_r == '0) begin
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_F_RD;
                end
              end
            endcase
          end
        end
        S_RM_RD: begin
          state_r <= S_RM_WR;
        end
        S_RM_WR: begin
          if (IDX_W'(idx_r + IDX_W'(1)) == last_idx) begin
            out_valid_r           <= 1'b1;
            count_r               <= count_r - CNT_W'(1);
            out_rsp_r.entry_count <= count_r - CNT_W'(1);
            state_r               <= S_IDLE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_RM_RD;
          end
        end
        S_F_RD: begin
          state_r <= S_F_SUB;
        end
        S_F_SUB: begin
          sx_r  <= seg.sx;
          sy_r  <= seg.sy;
          abx_r <= $signed({seg.ex[C-1], seg.ex}) - $signed({seg.sx[C-1], seg.sx});
          aby_r <= $signed({seg.ey[C-1], seg.ey}) - $signed({seg.sy[C-1], seg.sy});
          acx_r <= $signed({qx_r[C-1], qx_r}) - $signed({seg.sx[C-1], seg.sx});
          acy_r <= $signed({qy_r[C-1], qy_r}) - $signed({seg.sy[C-1], seg.sy});
          state_r <= S_F_M1;
        end
        S_F_M1: begin
          pdx_r   <= abx_r * acx_r;
          pdy_r   <= aby_r * acy_r;
          state_r <= S_F_M2;
        end
        S_F_M2: begin
          dot_r   <= $signed({pdx_r[PR_W-1], pdx_r}) + $signed({pdy_r[PR_W-1], pdy_r});
          lxx_r   <= abx_r * abx_r;
          lyy_r   <= aby_r * aby_r;
          state_r <= S_F_LEN;
        end
        S_F_LEN: begin
          len2_r    <= len2_w;
          rem_r     <= {1'b0, $unsigned(dot_r)};
          bit_cnt_r <= '0;
          if (len2_w == '0 || !dot_pos) begin
            t_r     <= '0;
            state_r <= S_F_SC;
          end else if ($unsigned(dot_r) >= len2_w) begin
            t_r     <= T_W'(65536);
            state_r <= S_F_SC;
          end else begin
            t_r     <= '0;
            state_r <= S_F_DIV;
          end
        end
        S_F_DIV: begin
          // one quotient bit per cycle
          t_r       <= {t_r[T_W-2:0], ge};
          rem_r     <= ge ? (r2 - {1'b0, len2_r}) : r2;
          bit_cnt_r <= bit_cnt_r + 4'd1;
          if (bit_cnt_r == 4'd15) begin
            state_r <= S_F_SC;
          end
        end
        S_F_SC: begin
          mx_r    <= magx * t_r;
          my_r    <= magy * t_r;
          state_r <= S_F_RND;
        end
        S_F_RND: begin
          dx_r    <= dx_w;
          dy_r    <= dy_w;
          state_r <= S_F_SQ;
        end
        S_F_SQ: begin
          sqx_r   <= dx_r * dx_r;
          sqy_r   <= dy_r * dy_r;
          state_r <= S_F_CMP;
        end
        S_F_CMP: begin
          if (better) begin
            hit_r  <= 1'b1;
            best_r <= d2;
            hidx_r <= idx_r;
          end
          if (idx_r == last_idx) begin
            out_valid_r         <= 1'b1;
            out_rsp_r.hit       <= better | hit_r;
            out_rsp_r.hit_index <= better ? idx_r : hidx_r;
            state_r             <= S_IDLE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_F_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
